// ===== hw/rtl/tfhc_pkg.sv =====
// ----------------------------------------------------------------------------
// tfhc_pkg
// Shared types and constants of the thermal fan hysteresis controller.
// ----------------------------------------------------------------------------
`default_nettype none

package tfhc_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_SPECIFIED_SPEED = 2'd0;
    localparam logic [1:0] REG_CPU_LIMIT       = 2'd1;
    localparam logic [1:0] REG_GPU_LIMIT       = 2'd2;
    localparam logic [1:0] REG_TWO_FAN_MODE    = 2'd3;

    // configuration reset values
    localparam logic [7:0] SPECIFIED_SPEED_RST = 8'd128;
    localparam logic [7:0] CPU_LIMIT_RST       = 8'd50;
    localparam logic [7:0] GPU_LIMIT_RST       = 8'd70;
    localparam logic       TWO_FAN_MODE_RST    = 1'b1;

    // excess thresholds, signed over temp - limit
    localparam logic signed [9:0] OVER_MARGIN    = 10'sd8;
    localparam logic signed [9:0] RELEASE_MARGIN = 10'sd6;
    localparam logic signed [9:0] COLD_MARGIN    = -10'sd1;
    localparam logic signed [9:0] ZERO_EXCESS    = 10'sd0;

    localparam logic [7:0] FULL_SPEED = 8'hff;
    localparam logic [7:0] STOP_SPEED = 8'h00;

    // fan indexes
    localparam logic FAN_CPU = 1'b0;
    localparam logic FAN_GPU = 1'b1;

    // decoded speed request of one tick, from front to back
    typedef struct packed {
        logic       a0_valid;
        logic [7:0] a0_speed;
        logic       a1_valid;
        logic       a1_fan;
        logic [7:0] a1_speed;
    } cmd_t;

    // one speed write as seen on the result side
    typedef struct packed {
        logic       fan_select;
        logic [7:0] drive_speed;
        logic       final_write;
    } res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tfhc_front.sv =====
// ----------------------------------------------------------------------------
// tfhc_front
// Holds configuration and override flags, classifies each tick into speed
// requests for the CPU check and the GPU check.
// ----------------------------------------------------------------------------
`default_nettype none

module tfhc_front
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [1:0]    cfg_index,
    input  wire logic [7:0]    cfg_data,
    input  wire logic          accept,
    input  wire logic [7:0]    cpu_temp,
    input  wire logic [7:0]    gpu_temp,
    output tfhc_pkg::cmd_t     cmd
);
    import tfhc_pkg::*;

    logic [7:0]        spec_reg;
    logic [7:0]        cpu_lim_reg;
    logic [7:0]        gpu_lim_reg;
    logic              two_reg;
    logic [1:0]        ovr_reg;
    logic [1:0]        ovr_mid;
    logic [1:0]        ovr_next;
    logic signed [9:0] ex0;
    logic signed [9:0] ex1;
    logic              full0;
    logic              spec0;
    logic              cold0;
    logic              full1;
    logic              spec1;
    logic              cold1;
    logic              look1;
    logic              fan1;
    logic              ovr1;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spec_reg    <= SPECIFIED_SPEED_RST;
            cpu_lim_reg <= CPU_LIMIT_RST;
            gpu_lim_reg <= GPU_LIMIT_RST;
            two_reg     <= TWO_FAN_MODE_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_SPECIFIED_SPEED: spec_reg    <= cfg_data;
                REG_CPU_LIMIT:       cpu_lim_reg <= cfg_data;
                REG_GPU_LIMIT:       gpu_lim_reg <= cfg_data;
                REG_TWO_FAN_MODE:    two_reg     <= cfg_data[0];
                default:             spec_reg    <= spec_reg;
            endcase
        end
    end

    // signed excess of each sensor over its limit
    assign ex0 = $signed({2'b00, cpu_temp}) - $signed({2'b00, cpu_lim_reg});
    assign ex1 = $signed({2'b00, gpu_temp}) - $signed({2'b00, gpu_lim_reg});

    // cpu check then gpu check, the second sees flags left by the first
    always_comb
    begin
        full0 = (ex0 > OVER_MARGIN);
        spec0 = !full0 && (!ovr_reg[FAN_CPU] || (ex0 < RELEASE_MARGIN))
                && (ex0 > ZERO_EXCESS);
        cold0 = !full0 && !spec0 && (ex0 < COLD_MARGIN);

        ovr_mid = ovr_reg;
        if (full0)
        begin
            ovr_mid[FAN_CPU] = 1'b1;
        end
        else if (spec0)
        begin
            ovr_mid[FAN_CPU] = 1'b0;
        end

        // shared fan: a started fan ends the scan
        look1 = two_reg || !(full0 || spec0);
        fan1  = two_reg ? FAN_GPU : FAN_CPU;
        ovr1  = ovr_mid[fan1];

        full1 = look1 && (ex1 > OVER_MARGIN);
        spec1 = look1 && !full1 && (!ovr1 || (ex1 < RELEASE_MARGIN))
                && (ex1 > ZERO_EXCESS);
        cold1 = look1 && !full1 && !spec1 && (ex1 < COLD_MARGIN)
                && (two_reg || (ex0 < COLD_MARGIN));

        ovr_next = ovr_mid;
        if (full1)
        begin
            ovr_next[fan1] = 1'b1;
        end
        else if (spec1)
        begin
            ovr_next[fan1] = 1'b0;
        end

        cmd.a0_valid = full0 || spec0 || cold0;
        cmd.a0_speed = full0 ? FULL_SPEED : (spec0 ? spec_reg : STOP_SPEED);
        cmd.a1_valid = full1 || spec1 || cold1;
        cmd.a1_fan   = fan1;
        cmd.a1_speed = full1 ? FULL_SPEED : (spec1 ? spec_reg : STOP_SPEED);
    end

    // override flags advance on each accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovr_reg <= 2'b00;
        end
        else if (accept)
        begin
            ovr_reg <= ovr_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/tfhc_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// tfhc_cmd_queue
// Two-entry queue of decoded tick requests between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module tfhc_cmd_queue
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire tfhc_pkg::cmd_t cmd_in,
    output logic                full,
    input  wire logic           pop,
    output logic                valid,
    output tfhc_pkg::cmd_t      cmd_out
);
    import tfhc_pkg::*;

    cmd_t       mem [2];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       do_push;
    logic       do_pop;

    assign full    = (cnt_reg == 2'd2);
    assign valid   = (cnt_reg != 2'd0);
    assign cmd_out = mem[rp_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    // occupancy
    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_push)
            begin
                wp_reg <= !wp_reg;
            end
            if (do_pop)
            begin
                rp_reg <= !rp_reg;
            end
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wp_reg] <= cmd_in;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/tfhc_back.sv =====
// ----------------------------------------------------------------------------
// tfhc_back
// Applies tick requests against the programmed fan speeds, keeps only the
// changes and queues them as speed writes for the result side.
// ----------------------------------------------------------------------------
`default_nettype none

module tfhc_back
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cmd_valid,
    input  wire tfhc_pkg::cmd_t cmd,
    output logic                cmd_pop,
    output logic                empty,
    input  wire logic           pop,
    output logic                fan_select,
    output logic [7:0]          drive_speed,
    output logic                final_write
);
    import tfhc_pkg::*;

    logic [7:0] prog_reg [2];
    logic [7:0] prog_mid [2];
    logic [7:0] prog_next [2];
    res_t       mem [4];
    logic [1:0] wp_reg;
    logic [1:0] rp_reg;
    logic [2:0] cnt_reg;
    logic [2:0] cnt_next;
    logic       e0;
    logic       e1;
    res_t       r0;
    res_t       r1;
    res_t       first;
    logic [1:0] n_push;
    logic       do_pop;

    // take a request when two result slots are free
    assign cmd_pop = cmd_valid && (cnt_reg <= 3'd2);
    assign do_pop  = pop && !empty;
    assign empty   = (cnt_reg == 3'd0);

    assign fan_select  = mem[rp_reg].fan_select;
    assign drive_speed = mem[rp_reg].drive_speed;
    assign final_write = mem[rp_reg].final_write;

    // change detection, cpu request first
    always_comb
    begin
        prog_mid = prog_reg;
        e0 = cmd.a0_valid && (prog_reg[FAN_CPU] != cmd.a0_speed);
        if (e0)
        begin
            prog_mid[FAN_CPU] = cmd.a0_speed;
        end
        e1 = cmd.a1_valid && (prog_mid[cmd.a1_fan] != cmd.a1_speed);

        prog_next = prog_mid;
        if (e1)
        begin
            prog_next[cmd.a1_fan] = cmd.a1_speed;
        end

        r0.fan_select  = FAN_CPU;
        r0.drive_speed = cmd.a0_speed;
        r0.final_write = !e1;
        r1.fan_select  = cmd.a1_fan;
        r1.drive_speed = cmd.a1_speed;
        r1.final_write = 1'b1;
        first = e0 ? r0 : r1;

        n_push = cmd_pop ? ({1'b0, e0} + {1'b0, e1}) : 2'd0;
        cnt_next = cnt_reg + {1'b0, n_push} - {2'b00, do_pop};
    end

    // programmed speeds and result queue control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prog_reg[FAN_CPU] <= STOP_SPEED;
            prog_reg[FAN_GPU] <= STOP_SPEED;
            wp_reg            <= 2'd0;
            rp_reg            <= 2'd0;
            cnt_reg           <= 3'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            wp_reg  <= wp_reg + n_push;
            if (do_pop)
            begin
                rp_reg <= rp_reg + 2'd1;
            end
            if (cmd_pop)
            begin
                prog_reg[FAN_CPU] <= prog_next[FAN_CPU];
                prog_reg[FAN_GPU] <= prog_next[FAN_GPU];
            end
        end
    end

    // result storage, up to two writes per request
    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
        begin
            mem[wp_reg] <= first;
        end
        if (n_push == 2'd2)
        begin
            mem[wp_reg + 2'd1] <= r1;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/thermal_fan_hysteresis_controller_unit.sv =====
// ----------------------------------------------------------------------------
// thermal_fan_hysteresis_controller_unit
// Thermal fan control with hysteresis: turns temperature ticks into fan
// speed writes.
// ----------------------------------------------------------------------------
// Usage
//   Input queue: present cpu_temp and gpu_temp with push; the tick is taken
//   at an edge with push high and full low.
//   Result queue: while empty is low the oldest speed write is on
//   fan_select, drive_speed and final_write; pop takes it. A tick gives zero,
//   one or two writes; final_write marks the last write of its tick.
//   Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data, written
//   while no tick is in flight; cfg_ready is always high.
//   The request of a tick is registered in the request queue and its writes in
//   the result queue. Throughput: one tick per cycle while ticks give at most
//   one write and pop takes each write as soon as it is shown; ticks that give
//   two writes are held back by the single read port of the four-entry result queue.
//   Reset clears the queues, override flags and programmed speeds (zero)
//   and loads the configuration reset values. When pop stays low the result
//   queue fills, the back end stops taking requests, and full rises once
//   the two-entry request queue is also full; nothing is dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module thermal_fan_hysteresis_controller_unit
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_data,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] cpu_temp,
    input  wire logic [7:0] gpu_temp,
    output logic            empty,
    input  wire logic       pop,
    output logic            fan_select,
    output logic [7:0]      drive_speed,
    output logic            final_write
);
    import tfhc_pkg::*;

    cmd_t cmd_front;
    cmd_t cmd_back;
    logic accept;
    logic cmd_valid;
    logic cmd_pop;

    assign accept = push && !full;

    // classification of each tick
    tfhc_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .cpu_temp  (cpu_temp),
        .gpu_temp  (gpu_temp),
        .cmd       (cmd_front)
    );

    // decoupling queue
    tfhc_cmd_queue u_cmd_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .cmd_in  (cmd_front),
        .full    (full),
        .pop     (cmd_pop),
        .valid   (cmd_valid),
        .cmd_out (cmd_back)
    );

    // speed tracking and result queue
    tfhc_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd_back),
        .cmd_pop     (cmd_pop),
        .empty       (empty),
        .pop         (pop),
        .fan_select  (fan_select),
        .drive_speed (drive_speed),
        .final_write (final_write)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/tfhc_checker.sv =====
// ----------------------------------------------------------------------------
// tfhc_checker
// Port-level checks on the fan controller, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tfhc_checker
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       full,
    input  wire logic       empty,
    input  wire logic       pop,
    input  wire logic       fan_select,
    input  wire logic [7:0] drive_speed,
    input  wire logic       final_write
);

    // a waiting write that is not taken stays as it is
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(fan_select)
                              && $stable(drive_speed) && $stable(final_write)))
    else $error("waiting speed write changed before it was taken");

    // the second write of a tick is queued together with the first
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !final_write) |=> !empty)
    else $error("first write of a pair taken but its partner is missing");

    // a full request queue that stays full means the result side is backed up
    assert property (@(posedge clk) disable iff (!rst_n)
        ($past(full) && full) |-> !empty)
    else $error("input held full while no result waits");

endmodule

bind thermal_fan_hysteresis_controller_unit tfhc_checker u_tfhc_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .full        (full),
    .empty       (empty),
    .pop         (pop),
    .fan_select  (fan_select),
    .drive_speed (drive_speed),
    .final_write (final_write)
);

`default_nettype wire
